[rtl/image_convolution_mirror_edge_defines.svh]
// Assertion macros for the image convolution block
`ifndef IMAGE_CONVOLUTION_MIRROR_EDGE_DEFINES_SVH
`define IMAGE_CONVOLUTION_MIRROR_EDGE_DEFINES_SVH
// Assert that an antecedent implies a consequent on the next clock
`define ICME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
// Assert that a condition always holds
`define ICME_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

[rtl/icme_pkg.sv]
// Shared constants and helpers for the image convolution block
`timescale 1ns / 1ps
package icme_pkg;
	localparam int MAX_WIDTH_D  = 256;
	localparam int MAX_HEIGHT_D = 256;
	localparam int MAX_KERNEL_D = 5;
	localparam int COEF_ROWS    = 5;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 40;
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KSIZE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd7;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic        start;
		logic signed [24:0] dividend;
		logic [11:0] divisor;
	} div_req_t;
endpackage

[rtl/icme_divider.sv]
// Radix-2 signed-by-unsigned divider, truncating toward zero, clamped to 0..255
`timescale 1ns / 1ps
`include "image_convolution_mirror_edge_defines.svh"
module icme_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  icme_pkg::div_req_t req,
	output logic              done,
	output logic [7:0]        result
);
	logic [24:0] rem_q;
	logic [24:0] quo_q;
	logic [24:0] num_q;
	logic [11:0] den_q;
	logic        neg_q;
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [25:0] trial;

	assign trial = {rem_q, num_q[24]} - {14'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd24) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[24];
			num_q <= req.dividend[24] ? 25'(-req.dividend) : 25'(req.dividend);
			den_q <= (req.divisor == 12'd0) ? 12'd1 : req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[23:0], 1'b0};
			if (!trial[25]) begin
				rem_q <= trial[24:0];
				quo_q <= {quo_q[23:0], 1'b1};
			end else begin
				rem_q <= {rem_q[23:0], num_q[24]};
				quo_q <= {quo_q[23:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (neg_q || quo_q == 25'd0)
			result = 8'd0;
		else if (quo_q > 25'd255)
			result = 8'd255;
		else
			result = quo_q[7:0];
	end

	`ICME_ASSERT_NEXT(a_done_from_busy, clk, arst_n, done, !busy_q, "divider done while busy")
	`ICME_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, !busy_q || cnt_q <= 5'd24, "divider count overflow")
	`ICME_ASSERT_NEXT(a_start_busy, clk, arst_n, req.start, busy_q, "divider did not start")
endmodule

[rtl/image_convolution_mirror_edge.sv]
// Top level of the mirrored-edge 2-D image convolution block
// Usage:
//  s_axis carries one transaction per pixel command: tuser selects the
//  operation (0 load, 1 read), tdata holds the 8-bit load sample.
//  Loads store the sample in raster order into the frame memory and produce
//  no output; back-to-back loads are taken one per cycle. A load after reads
//  starts a new frame.
//  Each read produces one m_axis transaction: tdata is the filtered pixel,
//  tlast marks the final pixel of the frame (or an empty frame).
//  A read first counts the complete rows h by repeated subtraction (h at
//  most MAX_HEIGHT), then fetches the n*n taps through the one frame
//  memory read port, one per cycle, then adds the last product and runs
//  the 25-step serial divider; an empty frame skips the taps and the
//  divider. The next transaction is taken from the cycle after the result
//  leaves. Configuration writes through cfg_we/cfg_index/cfg_data are to
//  be made only while the block is idle; the block does not enforce it.
//  Reset clears the load count and output position; the frame memory is
//  not cleared and needs no clearing pass. A stalled m_axis holds its
//  result; s_axis stays not ready until the result has been taken.
`timescale 1ns / 1ps
`include "image_convolution_mirror_edge_defines.svh"
module image_convolution_mirror_edge #(
	parameter int MAX_WIDTH  = icme_pkg::MAX_WIDTH_D,
	parameter int MAX_HEIGHT = icme_pkg::MAX_HEIGHT_D,
	parameter int MAX_KERNEL = icme_pkg::MAX_KERNEL_D
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // pixel_in
	input  logic                            s_axis_tuser,  // operation
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [7:0]                      m_axis_tdata,  // pixel_out
	output logic                            m_axis_tlast,  // last
	input  logic                            cfg_we,
	input  logic [icme_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [icme_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int CW    = AW + 1;
	localparam int WW    = XW + 1;
	localparam int HW    = YW + 1;
	localparam int KW    = $clog2(MAX_KERNEL + 1);
	localparam int SW    = XW + 4;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HDIV = 3'd1;
	localparam logic [2:0] ST_TAP  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [39:0] coef_q [icme_pkg::COEF_ROWS];
	logic [11:0] divisor_q;
	logic [2:0]  ksize_q;
	logic [8:0]  width_q;

	logic [7:0]  mem [DEPTH];
	logic [7:0]  rd_data;
	logic [AW-1:0] rd_addr;
	logic        rd_en;

	logic [2:0]  state_q;
	logic [CW-1:0] load_count_q;
	logic        emitting_q;
	logic [XW-1:0] out_col_q;
	logic [YW-1:0] out_row_q;
	logic [HW-1:0] h_q;
	logic [CW-1:0] hrem_q;
	logic [KW-1:0] ti_q, tj_q;
	logic        tap_v_s1;
	logic signed [7:0] coef_s1;
	logic signed [24:0] acc_q;
	logic        last_q;
	logic        div_done;
	logic [7:0]  div_result;
	logic        div_req_busy_q;
	icme_pkg::div_req_t div_req;

	logic [WW-1:0] w_eff;
	logic [KW-1:0] n_eff;
	logic [KW-1:0] half;
	logic signed [SW-1:0] cx, cy, mx, my;
	logic signed [7:0] coef_cur;
	logic        tap_end;
	logic        acc_fire;

	always_comb begin
		if (width_q == 9'd0)
			w_eff = WW'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(width_q);
		if (ksize_q == 3'd0)
			n_eff = KW'(1);
		else if (32'(ksize_q) > MAX_KERNEL)
			n_eff = KW'(MAX_KERNEL);
		else
			n_eff = KW'(ksize_q);
		half = n_eff >> 1;
	end

	function automatic logic signed [SW-1:0] edge_map(
		input logic signed [SW-1:0] c,
		input logic signed [SW-1:0] size
	);
		logic signed [SW-1:0] m;
		begin
			m = c;
			if (c < 0)
				m = SW'(1) - c;
			else if (c >= size)
				m = (size <<< 1) - SW'(3) - c;
			if (m < 0)
				m = '0;
			if (m > size - SW'(1))
				m = size - SW'(1);
			return m;
		end
	endfunction

	always_comb begin
		cx = SW'(out_col_q) + SW'(half) - SW'(ti_q);
		cy = SW'(out_row_q) + SW'(half) - SW'(tj_q);
		mx = edge_map(cx, SW'(w_eff));
		my = edge_map(cy, SW'(h_q));
		rd_addr = AW'(my[YW-1:0]) * AW'(w_eff) + AW'(mx[XW-1:0]);
		if (32'(tj_q) < icme_pkg::COEF_ROWS && 32'(ti_q) < icme_pkg::COEF_ROWS)
			coef_cur = coef_q[3'(tj_q)][8*3'(ti_q) +: 8];
		else
			coef_cur = '0;
		tap_end = (ti_q == n_eff - KW'(1)) && (tj_q == n_eff - KW'(1));
		rd_en   = (state_q == ST_TAP);
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = (h_q == '0) ? 8'd0 : div_result;
	assign m_axis_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= '0;
			coef_q[1] <= '0;
			coef_q[2] <= '0;
			coef_q[3] <= '0;
			coef_q[4] <= '0;
			divisor_q <= 12'd1;
			ksize_q   <= 3'd3;
			width_q   <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				icme_pkg::REG_DIVISOR: divisor_q <= cfg_data[11:0];
				icme_pkg::REG_KSIZE:   ksize_q   <= cfg_data[2:0];
				icme_pkg::REG_WIDTH:   width_q   <= cfg_data[8:0];
				default:               coef_q[cfg_index] <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready && s_axis_tuser == icme_pkg::OP_LOAD
		    && (emitting_q || 32'(load_count_q) < DEPTH))
			mem[emitting_q ? '0 : AW'(load_count_q)] <= s_axis_tdata;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

	assign acc_fire = tap_v_s1;
	assign div_req  = {(state_q == ST_DIV) && !tap_v_s1 && !div_req_busy_q, acc_q, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			load_count_q   <= '0;
			emitting_q     <= 1'b0;
			out_col_q      <= '0;
			out_row_q      <= '0;
			tap_v_s1       <= 1'b0;
			div_req_busy_q <= 1'b0;
		end else begin
			tap_v_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						if (s_axis_tuser == icme_pkg::OP_LOAD) begin
							emitting_q <= 1'b0;
							if (emitting_q) begin
								load_count_q <= CW'(1);
								out_col_q    <= '0;
								out_row_q    <= '0;
							end else if (32'(load_count_q) < DEPTH) begin
								load_count_q <= load_count_q + CW'(1);
							end
						end else begin
							emitting_q <= 1'b1;
							state_q    <= ST_HDIV;
						end
					end
				end
				ST_HDIV: begin
					if (hrem_q < CW'(w_eff) || 32'(h_q) >= MAX_HEIGHT) begin
						if (h_q == '0) begin
							state_q <= ST_OUT;
						end else begin
							if (32'(out_col_q) >= 32'(w_eff) || 32'(out_row_q) >= 32'(h_q)) begin
								out_col_q <= '0;
								out_row_q <= '0;
							end
							state_q <= ST_TAP;
						end
					end
				end
				ST_TAP: begin
					tap_v_s1 <= 1'b1;
					if (tap_end)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_req.start)
						div_req_busy_q <= 1'b1;
					if (div_done) begin
						div_req_busy_q <= 1'b0;
						state_q        <= ST_OUT;
						if (last_q) begin
							out_col_q <= '0;
							out_row_q <= '0;
						end else if (32'(out_col_q) + 1 >= 32'(w_eff)) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + YW'(1);
						end else begin
							out_col_q <= out_col_q + XW'(1);
						end
					end
				end
				ST_OUT: begin
					if (m_axis_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				h_q    <= '0;
				hrem_q <= load_count_q;
				ti_q   <= '0;
				tj_q   <= '0;
				acc_q  <= '0;
				last_q <= 1'b1;
			end
			ST_HDIV: begin
				if (!(hrem_q < CW'(w_eff) || 32'(h_q) >= MAX_HEIGHT)) begin
					hrem_q <= hrem_q - CW'(w_eff);
					h_q    <= h_q + HW'(1);
				end else if (h_q != '0) begin
					if (32'(out_col_q) >= 32'(w_eff) || 32'(out_row_q) >= 32'(h_q))
						last_q <= (32'(w_eff) == 1) && (32'(h_q) == 1);
					else
						last_q <= (32'(out_col_q) + 1 >= 32'(w_eff))
						          && (32'(out_row_q) + 1 >= 32'(h_q));
				end else begin
					last_q <= 1'b1;
				end
			end
			ST_TAP: begin
				coef_s1 <= coef_cur;
				if (ti_q == n_eff - KW'(1)) begin
					ti_q <= '0;
					tj_q <= tj_q + KW'(1);
				end else begin
					ti_q <= ti_q + KW'(1);
				end
			end
			default: ;
		endcase
		if (acc_fire)
			acc_q <= acc_q + 25'(signed'({1'b0, rd_data}) * coef_s1);
	end

	icme_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.result (div_result)
	);

	`ICME_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped under stall")
	`ICME_ASSERT_ALWAYS(a_ready_excl, clk, arst_n, !(s_axis_tready && m_axis_tvalid), "input ready while result pending")
	`ICME_ASSERT_ALWAYS(a_count_cap, clk, arst_n, 32'(load_count_q) <= DEPTH, "load count past frame memory")
endmodule

[tb/image_convolution_mirror_edge_test.sv]
// Self-checking testbench for the mirrored-edge 2-D image convolution block
`timescale 1ns / 1ps
module image_convolution_mirror_edge_test;
	typedef logic [icme_pkg::CFG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_COEF0 = 3'd0;
	localparam int STORE_DEPTH = icme_pkg::MAX_WIDTH_D * icme_pkg::MAX_HEIGHT_D;
	localparam int CYCLE_LIMIT = 2500000;
	localparam int SETTLE_CYCLES = 80;
	localparam int RANDOM_ITEMS = 1350;

	typedef struct packed {
		logic [7:0] pixel;
		logic       last;
	} conv_out_t;

	typedef struct {
		bit                              is_cfg;
		logic [icme_pkg::CFG_IDX_W-1:0]  idx;
		logic [icme_pkg::CFG_DATA_W-1:0] val;
		logic                            op;
		logic [7:0]                      px;
		bit                              typed;
		logic [7:0]                      t_pix;
		logic                            t_last;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;  // pixel_in
	logic s_axis_tuser = 1'b0;      // operation
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;       // pixel_out
	logic m_axis_tlast;             // last
	logic cfg_we = 1'b0;
	logic [icme_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [icme_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	image_convolution_mirror_edge u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [7:0] frame_mem [0:STORE_DEPTH-1];
	int unsigned load_cnt, out_x, out_y;
	bit emit_phase;
	logic [39:0] coef_q [0:icme_pkg::COEF_ROWS-1];
	logic [11:0] div_q;
	logic [2:0] ksize_q;
	logic [8:0] width_q;

	conv_out_t pending_pixels[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	step_row_t dir_rows[$];

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("image_convolution_mirror_edge_test: done, errors");
			$finish;
		end
	end

	task automatic note_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic int mirror_coord(input int c, input int size);
		int m;
		m = c;
		if (m < 0)
			m = 1 - m;
		else if (m >= size)
			m = 2 * size - 3 - m;
		if (m < 0)
			m = 0;
		if (m > size - 1)
			m = size - 1;
		return m;
	endfunction

	function automatic int coef_val(input int row, input int col);
		logic signed [7:0] b;
		if (row >= icme_pkg::COEF_ROWS || col >= icme_pkg::COEF_ROWS)
			return 0;
		b = coef_q[row][8*col +: 8];
		return int'(b);
	endfunction

	task automatic filter_next(input logic op, input logic [7:0] px, output bit has,
			output conv_out_t r);
		int w, h, n, d, half, cy, cx, sum, q;
		has = 0;
		r = '0;
		if (op == icme_pkg::OP_LOAD) begin
			if (emit_phase) begin
				emit_phase = 0;
				load_cnt = 0;
				out_x = 0;
				out_y = 0;
			end
			if (load_cnt < STORE_DEPTH) begin
				frame_mem[load_cnt] = px;
				load_cnt++;
			end
		end else begin
			has = 1;
			w = (width_q < 1) ? 1 : (width_q > icme_pkg::MAX_WIDTH_D) ? icme_pkg::MAX_WIDTH_D
				: int'(width_q);
			h = load_cnt / w;
			if (h > icme_pkg::MAX_HEIGHT_D)
				h = icme_pkg::MAX_HEIGHT_D;
			n = (ksize_q < 1) ? 1 : (ksize_q > icme_pkg::MAX_KERNEL_D) ? icme_pkg::MAX_KERNEL_D
				: int'(ksize_q);
			d = (div_q == 0) ? 1 : int'(div_q);
			emit_phase = 1;
			if (h == 0) begin
				r.pixel = 8'd0;
				r.last = 1'b1;
			end else begin
				if (out_x >= w || out_y >= h) begin
					out_x = 0;
					out_y = 0;
				end
				half = n / 2;
				sum = 0;
				for (int j = 0; j < n; j++) begin
					cy = mirror_coord(int'(out_y) + half - j, h);
					for (int i = 0; i < n; i++) begin
						cx = mirror_coord(int'(out_x) + half - i, w);
						sum += int'(frame_mem[cy * w + cx]) * coef_val(j, i);
					end
				end
				q = sum / d;
				if (q < 0)
					q = 0;
				if (q > 255)
					q = 255;
				r.pixel = q[7:0];
				if (out_x + 1 >= w && out_y + 1 >= h) begin
					r.last = 1'b1;
					out_x = 0;
					out_y = 0;
				end else begin
					r.last = 1'b0;
					out_x++;
					if (out_x >= w) begin
						out_x = 0;
						out_y++;
					end
				end
			end
		end
	endtask

	task automatic write_reg(input logic [icme_pkg::CFG_IDX_W-1:0] idx,
			input logic [icme_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < icme_pkg::COEF_ROWS)
			coef_q[idx] = val;
		else if (idx == icme_pkg::REG_DIVISOR)
			div_q = val[11:0];
		else if (idx == icme_pkg::REG_KSIZE)
			ksize_q = val[2:0];
		else
			width_q = val[8:0];
		@(posedge clk);
	endtask

	task automatic settle();
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(input logic op, input logic [7:0] px, input bit typed,
			input conv_out_t typed_out);
		bit has;
		conv_out_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= px;
		do
			@(posedge clk);
		while (!s_axis_tready);
		filter_next(op, px, has, r);
		items_sent++;
		if (has) begin
			if (typed && r != typed_out)
				note_mismatch($sformatf("table row expects %h/%b, predictor gives %h/%b",
					typed_out.pixel, typed_out.last, r.pixel, r.last));
			pending_pixels.push_back(r);
		end
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		conv_out_t got, want;
		forever begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.pixel = m_axis_tdata;
				got.last = m_axis_tlast;
				if (pending_pixels.size() == 0) begin
					note_mismatch("output transaction with nothing expected");
				end else begin
					want = pending_pixels.pop_front();
					if (got.pixel !== want.pixel)
						note_mismatch($sformatf("pixel_out %h, expected %h", got.pixel,
							want.pixel));
					if (got.last !== want.last)
						note_mismatch($sformatf("last %b, expected %b", got.last,
							want.last));
				end
			end
		end
	end

	function automatic step_row_t cfg_row(input logic [icme_pkg::CFG_IDX_W-1:0] idx,
			input logic [icme_pkg::CFG_DATA_W-1:0] val);
		step_row_t r;
		r = '{1, idx, val, icme_pkg::OP_LOAD, 8'd0, 0, 8'd0, 1'b0};
		return r;
	endfunction

	function automatic step_row_t item_row(input logic op, input logic [7:0] px,
			input bit typed, input logic [7:0] tp, input logic tl);
		step_row_t r;
		r = '{0, REG_COEF0, '0, op, px, typed, tp, tl};
		return r;
	endfunction

	task automatic random_phase();
		int w, rows, extra, nloads, nreads;
		bit hold_mid;
		w = ($urandom_range(9) == 0) ? icme_pkg::MAX_WIDTH_D : $urandom_range(4, 8);
		if ($urandom_range(19) == 0)
			w = 4;
		for (int k = 0; k < icme_pkg::COEF_ROWS; k++)
			write_reg(REG_COEF0 + reg_idx_t'(k), 40'({$urandom, $urandom}));
		case ($urandom_range(3))
			0: write_reg(icme_pkg::REG_DIVISOR, 40'd1);
			1: write_reg(icme_pkg::REG_DIVISOR, 40'd4095);
			default: write_reg(icme_pkg::REG_DIVISOR, 40'($urandom_range(1, 64)));
		endcase
		write_reg(icme_pkg::REG_KSIZE, 40'($urandom_range(1, 5)));
		write_reg(icme_pkg::REG_WIDTH, 40'(w));
		rows = (w == icme_pkg::MAX_WIDTH_D) ? 1 : $urandom_range(0, 5);
		extra = $urandom_range(0, 3);
		nloads = w * rows + extra;
		nreads = (rows == 0) ? $urandom_range(1, 3)
			: ((w == icme_pkg::MAX_WIDTH_D) ? $urandom_range(1, 8)
			: $urandom_range(1, w * rows + 4));
		hold_mid = ($urandom_range(3) == 0);
		for (int k = 0; k < nloads; k++) begin
			if ($urandom_range(29) == 0)
				send_item(icme_pkg::OP_READ, 8'($urandom), 0, '0);
			send_item(icme_pkg::OP_LOAD, 8'($urandom), 0, '0);
		end
		for (int k = 0; k < nreads; k++) begin
			if (hold_mid && k == nreads / 2) begin
				s_axis_tvalid <= 1'b0;
				while (pending_pixels.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end
			send_item(icme_pkg::OP_READ, 8'($urandom), 0, '0);
		end
		stop_sending();
	endtask

	initial begin
		step_row_t row;
		conv_out_t typed_out;
		int phase;
		for (int k = 0; k < icme_pkg::COEF_ROWS; k++)
			coef_q[k] = '0;
		div_q = 12'd1;
		ksize_q = 3'd3;
		width_q = 9'd256;
		load_cnt = 0;
		out_x = 0;
		out_y = 0;
		emit_phase = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		dir_rows.push_back(item_row(icme_pkg::OP_READ, 8'hFF, 1, 8'd0, 1'b1));
		dir_rows.push_back(cfg_row(icme_pkg::REG_WIDTH, 40'd4));
		dir_rows.push_back(cfg_row(icme_pkg::REG_KSIZE, 40'd1));
		dir_rows.push_back(cfg_row(REG_COEF0, 40'h01));
		dir_rows.push_back(cfg_row(icme_pkg::REG_DIVISOR, 40'd1));
		dir_rows.push_back(item_row(icme_pkg::OP_LOAD, 8'h00, 0, 8'd0, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_LOAD, 8'hFF, 0, 8'd0, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_LOAD, 8'h80, 0, 8'd0, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_LOAD, 8'h01, 0, 8'd0, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_LOAD, 8'h07, 0, 8'd0, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_LOAD, 8'h7F, 0, 8'd0, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_LOAD, 8'h55, 0, 8'd0, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_LOAD, 8'hFA, 0, 8'd0, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_LOAD, 8'hAA, 0, 8'd0, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_READ, 8'h00, 1, 8'h00, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_READ, 8'h00, 1, 8'hFF, 1'b0));
		for (int k = 0; k < 7; k++)
			dir_rows.push_back(item_row(icme_pkg::OP_READ, 8'h00, 0, 8'd0, 1'b0));
		dir_rows.push_back(cfg_row(icme_pkg::REG_KSIZE, 40'd5));
		dir_rows.push_back(cfg_row(REG_COEF0 + reg_idx_t'(1), 40'h80_7F_80_7F_80));
		dir_rows.push_back(cfg_row(REG_COEF0 + reg_idx_t'(2), 40'h7F_7F_7F_7F_7F));
		dir_rows.push_back(cfg_row(REG_COEF0 + reg_idx_t'(3), 40'hFF_FF_FF_FF_FF));
		dir_rows.push_back(cfg_row(REG_COEF0 + reg_idx_t'(4), 40'h01_80_01_80_01));
		dir_rows.push_back(cfg_row(icme_pkg::REG_DIVISOR, 40'd4095));
		for (int k = 0; k < 3; k++)
			dir_rows.push_back(item_row(icme_pkg::OP_READ, 8'h00, 0, 8'd0, 1'b0));
		dir_rows.push_back(cfg_row(icme_pkg::REG_DIVISOR, 40'd3));
		dir_rows.push_back(item_row(icme_pkg::OP_READ, 8'h00, 0, 8'd0, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_LOAD, 8'h42, 0, 8'd0, 1'b0));
		dir_rows.push_back(item_row(icme_pkg::OP_READ, 8'h00, 1, 8'd0, 1'b1));

		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			if (row.is_cfg) begin
				stop_sending();
				settle();
				write_reg(row.idx, row.val);
			end else begin
				typed_out.pixel = row.t_pix;
				typed_out.last = row.t_last;
				send_item(row.op, row.px, row.typed, typed_out);
			end
		end
		stop_sending();

		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			case (phase % 5)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				3: begin send_idle_pct = 35; recv_stall_pct = 35; end
				default: begin send_idle_pct = $urandom_range(0, 50);
					recv_stall_pct = $urandom_range(0, 50); end
			endcase
			settle();
			random_phase();
			phase++;
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		settle();

		if (pending_pixels.size() != 0)
			note_mismatch("expected output never arrived");
		if (mismatch_count == 0)
			$display("image_convolution_mirror_edge_test: done, clean");
		else
			$display("image_convolution_mirror_edge_test: done, errors");
		$finish;
	end
endmodule

[image_convolution_mirror_edge.f]
+incdir+rtl
rtl/icme_pkg.sv
rtl/icme_divider.sv
rtl/image_convolution_mirror_edge.sv
tb/image_convolution_mirror_edge_test.sv
